@@ rtl/msr_pkg.sv @@
`default_nettype none

package msr_pkg;

    // Field widths of the command and result words.
    localparam int CMD_W   = 1;
    localparam int INDEX_W = 6;
    localparam int MID_W   = 7;
    localparam int VALUE_W = 32;

    // Default number of store entries.
    localparam int DEFAULT_STORE_DEPTH = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_MERGE = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RANGE = 1'b1;

endpackage

`default_nettype wire

@@ rtl/msr_if.sv @@
`default_nettype none

// Command channel: one word is either a store write or a merge request.
interface msr_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [msr_pkg::CMD_W-1:0]            command;
    logic [msr_pkg::INDEX_W-1:0]          write_index;
    logic signed [msr_pkg::VALUE_W-1:0]   write_value;
    logic [msr_pkg::INDEX_W-1:0]          range_start;
    logic [msr_pkg::MID_W-1:0]            range_mid;
    logic [msr_pkg::INDEX_W-1:0]          range_end;

    modport source (
        output valid, command, write_index, write_value, range_start, range_mid, range_end,
        input  ready
    );
    modport sink (
        input  valid, command, write_index, write_value, range_start, range_mid, range_end,
        output ready
    );
endinterface

// Result channel: one word per merged value, or one error word.
interface msr_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [msr_pkg::VALUE_W-1:0]   merged_value;
    logic [msr_pkg::INDEX_W-1:0]          merged_position;
    logic                                 last_of_run;
    logic                                 status;

    modport source (
        output valid, merged_value, merged_position, last_of_run, status,
        input  ready
    );
    modport sink (
        input  valid, merged_value, merged_position, last_of_run, status,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/merge_sorted_runs.sv @@
// A write command gives no result. A bad range gives its error word in the cycle after
// acceptance. A merge first merges both runs into the buffer memory, then copies the
// buffer back into the store while emitting each entry on the result channel; the copy
// pass waits while the result channel holds back, and the next command is taken only
// once the copy pass ends. The two passes follow from the single write port of each memory.
// Reset (synchronous, active low) clears the control state only; store contents are kept.
`default_nettype none

module merge_sorted_runs #(
    parameter int STORE_DEPTH = msr_pkg::DEFAULT_STORE_DEPTH
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    msr_cmd_if.sink   i_cmd,
    msr_res_if.source o_res
);

    // AW addresses the store; CW is a comfortable width for range checks so that
    // end+1 and the depth itself never overflow.
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = ((AW > 7) ? AW : 7) + 1;

    // One-hot controller. IDLE takes commands, MERGE streams both runs into the
    // buffer memory one word per cycle, COPY streams the buffer back into the store
    // and out on the result channel.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MERGE = 3'b010,
        S_COPY  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // The two memories. The element store has two read ports (left and right run
    // heads) and one write port; the merge buffer has one of each.
    logic signed [msr_pkg::VALUE_W-1:0] r_element_store [STORE_DEPTH];
    logic signed [msr_pkg::VALUE_W-1:0] r_merge_buffer  [STORE_DEPTH];

    logic signed [msr_pkg::VALUE_W-1:0] r_rd_left;
    logic signed [msr_pkg::VALUE_W-1:0] r_rd_right;
    logic signed [msr_pkg::VALUE_W-1:0] r_rd_buf;

    // Merge bookkeeping.
    logic [AW-1:0] r_start;
    logic [AW:0]   r_mid;
    logic [AW-1:0] r_end;
    logic [AW-1:0] r_last_k;
    logic [AW:0]   r_i, n_i;
    logic [AW:0]   r_j, n_j;
    logic [AW-1:0] r_k, n_k;

    // Output register, which decouples the result channel from the merge engine.
    logic                               r_ov;
    logic signed [msr_pkg::VALUE_W-1:0] r_val;
    logic [AW-1:0]                      r_pos;
    logic                               r_last;
    logic                               r_status;

    // Command decode, widened so that the range checks cannot wrap.
    logic [CW-1:0] cw_widx;
    logic [CW-1:0] cw_start;
    logic [CW-1:0] cw_mid;
    logic [CW-1:0] cw_end;
    logic [CW-1:0] cw_span;
    logic [CW-1:0] cw_pos;
    logic          range_ok;
    logic          range_empty;
    logic          cmd_fire;
    logic          out_free;

    // Datapath controls.
    logic                               left_ok;
    logic                               right_ok;
    logic                               take_left;
    logic                               copy_fire;
    logic                               store_we;
    logic [AW-1:0]                      store_wa;
    logic signed [msr_pkg::VALUE_W-1:0] store_wd;
    logic                               buf_we;
    logic signed [msr_pkg::VALUE_W-1:0] buf_wd;
    logic                               load_err;

    assign cw_widx  = CW'(i_cmd.write_index);
    assign cw_start = CW'(i_cmd.range_start);
    assign cw_mid   = CW'(i_cmd.range_mid);
    assign cw_end   = CW'(i_cmd.range_end);
    assign cw_span  = cw_end - cw_start;

    assign range_ok = (cw_start <= cw_mid) && (cw_mid <= cw_end + CW'(1))
                      && (cw_end < CW'(STORE_DEPTH));
    // Both runs empty: start sits one past end.
    assign range_empty = (cw_start == cw_end + CW'(1));

    // The output register can take a word when it is empty or being drained.
    assign out_free = !r_ov || o_res.ready;

    // Commands are taken only between merges, and only when an error word
    // would have somewhere to go.
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;

    // Merge step: the registered read data are the current heads of both runs.
    // A strict compare sends the right head first on a tie.
    assign left_ok   = (r_i < r_mid);
    assign right_ok  = (r_j <= {1'b0, r_end});
    assign take_left = left_ok && (!right_ok || (r_rd_left < r_rd_right));

    assign buf_we = (r_state == S_MERGE);
    assign buf_wd = take_left ? r_rd_left : r_rd_right;

    assign copy_fire = (r_state == S_COPY) && out_free;
    assign load_err  = cmd_fire && (i_cmd.command == msr_pkg::CMD_MERGE) && !range_ok;

    // The store write port is shared by write commands and the copy-back pass.
    always_comb begin
        store_we = 1'b0;
        store_wa = r_start + r_k;
        store_wd = r_rd_buf;
        if (copy_fire) begin
            store_we = 1'b1;
        end else if (cmd_fire && (i_cmd.command == msr_pkg::CMD_WRITE)
                     && (cw_widx < CW'(STORE_DEPTH))) begin
            store_we = 1'b1;
            store_wa = cw_widx[AW-1:0];
            store_wd = i_cmd.write_value;
        end
    end

    // Next-state logic. Read addresses are taken from the next pointer values so
    // that the synchronous memory read costs no bubble: while merging, the head
    // registers hold the entries at the current pointers.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (cmd_fire && (i_cmd.command == msr_pkg::CMD_MERGE)) begin
                    n_i = cw_start[AW:0];
                    n_j = cw_mid[AW:0];
                    n_k = '0;
                    if (range_ok && !range_empty) begin
                        n_state = S_MERGE;
                    end
                end
            end
            S_MERGE: begin
                n_i = r_i + (AW+1)'(take_left);
                n_j = r_j + (AW+1)'(!take_left);
                if (r_k == r_last_k) begin
                    n_k     = '0;
                    n_state = S_COPY;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            S_COPY: begin
                if (copy_fire) begin
                    if (r_k == r_last_k) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Element store: two synchronous read ports, one write port.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_element_store[store_wa] <= store_wd;
        end
        r_rd_left  <= r_element_store[n_i[AW-1:0]];
        r_rd_right <= r_element_store[n_j[AW-1:0]];
    end

    // Merge buffer. The copy pass may read the entry that the last merge step is
    // writing in the same cycle, so the write data are forwarded.
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_merge_buffer[r_k] <= buf_wd;
        end
        if (buf_we && (r_k == n_k)) begin
            r_rd_buf <= buf_wd;
        end else begin
            r_rd_buf <= r_merge_buffer[n_k];
        end
    end

    // Pointers and the captured range.
    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        if (cmd_fire) begin
            r_start  <= cw_start[AW-1:0];
            r_mid    <= cw_mid[AW:0];
            r_end    <= cw_end[AW-1:0];
            r_last_k <= cw_span[AW-1:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (copy_fire || load_err) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output payload. An error word carries zero value and position.
    always_ff @(posedge i_clk) begin
        if (copy_fire) begin
            r_val    <= r_rd_buf;
            r_pos    <= r_start + r_k;
            r_last   <= (r_k == r_last_k);
            r_status <= msr_pkg::STATUS_OK;
        end else if (load_err) begin
            r_val    <= '0;
            r_pos    <= '0;
            r_last   <= 1'b1;
            r_status <= msr_pkg::STATUS_BAD_RANGE;
        end
    end

    assign cw_pos = CW'(r_pos);

    assign o_res.valid           = r_ov;
    assign o_res.merged_value    = r_val;
    assign o_res.merged_position = cw_pos[msr_pkg::INDEX_W-1:0];
    assign o_res.last_of_run     = r_last;
    assign o_res.status          = r_status;

`ifndef ASSERT_OFF
    // Every merge step consumes exactly one element from one of the two runs.
    a_merge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |->
        ((r_i - {1'b0, r_start}) + (r_j - r_mid) == {1'b0, r_k}))
        else $error("merge pointers disagree with the buffer index");

    // While merging there is always an element left in at least one run.
    a_merge_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (left_ok || right_ok))
        else $error("merge step with both runs exhausted");

    // The buffer index never passes the end of the range.
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k <= r_last_k))
        else $error("buffer index beyond the merged range");

    // The word marked last of a merge returns the block to idle.
    a_copy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (copy_fire && (r_k == r_last_k)) |=> (r_state == S_IDLE))
        else $error("copy pass did not finish after its last word");

    // An error word is always the final word of its command.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_status == msr_pkg::STATUS_BAD_RANGE)) |-> r_last)
        else $error("error word without last_of_run");
`endif

endmodule

`default_nettype wire
